// File: design/periodic_task_timer_table_macros.svh
// ----------------------------------------------------------------------------
// periodic_task_timer_table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// consequent holds in the same cycle
`define PTT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types and constants of the periodic task timer table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int HANDLE_W   = 4;
    localparam int SLOT_COUNT = (MAX_TASKS < (1 << HANDLE_W)) ? MAX_TASKS : (1 << HANDLE_W);
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int UNIT_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [UNIT_W-1:0] TPU_RESET = UNIT_W'(10);

    // register index taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_TICKS_PER_UNIT = '0;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_ADD        = 2'd0,
        KIND_REMOVE     = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_EMPTY_TICK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic sweep_step;
        logic flush;
    } ptt_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       unit_done;
        logic       slot_fires;
        logic       pend_valid;
        logic       sweep_end;
        logic       out_free;
    } ptt_sts_t;

endpackage

// File: design/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// sequencer: input transfer, command execution, slot sweep and result flush
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ptt_sts_t sts,
    output ptt_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load_in  = 1'b1;
                    state_next   = S_EXEC;
                    s_ready_next = 1'b0;
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    cmd.exec = 1'b1;
                    if (sts.action == ACT_TICK && sts.unit_done) begin
                        state_next = S_SWEEP;
                    end else begin
                        state_next   = S_IDLE;
                        s_ready_next = 1'b1;
                    end
                end
            end
            S_SWEEP: begin
                // a firing slot pushes the held one out, so it needs a free output
                if (!(sts.slot_fires && sts.pend_valid && !sts.out_free)) begin
                    cmd.sweep_step = 1'b1;
                    if (sts.sweep_end) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush    = 1'b1;
                    state_next   = S_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = S_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// File: design/ptt_dp.sv
// ----------------------------------------------------------------------------
// ptt_dp
// timer slots, prescaler, held fire and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_dp
    import ptt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ptt_cmd_t            cmd,
    output ptt_sts_t            sts,
    input  logic [1:0]          s_action,
    input  logic [UNIT_W-1:0]   s_delay_units,
    input  logic [UNIT_W-1:0]   s_period_units,
    input  logic [HANDLE_W-1:0] s_handle_in,
    input  logic                cfg_we,
    input  logic [UNIT_W-1:0]   cfg_wdata,
    output logic [UNIT_W-1:0]   tpu_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [HANDLE_W-1:0] m_task_handle,
    output logic [1:0]          m_status,
    output logic                m_last
);

    logic [1:0]          in_action_reg;
    logic [UNIT_W-1:0]   in_delay_reg;
    logic [UNIT_W-1:0]   in_period_reg;
    logic [HANDLE_W-1:0] in_handle_reg;

    logic [UNIT_W-1:0]   tpu_reg;
    logic [UNIT_W-1:0]   prescale_reg;
    logic [SLOT_COUNT-1:0] active_reg;
    logic [UNIT_W-1:0]   rem_reg    [SLOT_COUNT];
    logic [UNIT_W-1:0]   reload_reg [SLOT_COUNT];
    logic [SLOT_W-1:0]   idx_reg;
    logic                pend_valid_reg;
    logic [SLOT_W-1:0]   pend_handle_reg;

    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [1:0]          out_status_reg;
    logic                out_last_reg;

    logic [UNIT_W-1:0]   div;
    logic [UNIT_W:0]     presc_inc;
    logic                unit_done;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic                rm_hit;
    logic                cur_act;
    logic [UNIT_W-1:0]   cur_rem;
    logic [UNIT_W-1:0]   cur_reload;
    logic                slot_fires;
    logic                out_free;
    logic                out_load;

    assign div       = (tpu_reg == '0) ? UNIT_W'(1) : tpu_reg;
    assign presc_inc = {1'b0, prescale_reg} + (UNIT_W+1)'(1);
    assign unit_done = presc_inc >= {1'b0, div};

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign rm_hit = ({1'b0, in_handle_reg} < (HANDLE_W+1)'(SLOT_COUNT))
                    && active_reg[in_handle_reg[SLOT_W-1:0]];

    assign cur_act    = active_reg[idx_reg];
    assign cur_rem    = rem_reg[idx_reg];
    assign cur_reload = reload_reg[idx_reg];
    assign slot_fires = cur_act && (cur_rem <= UNIT_W'(1));
    assign out_free   = !out_valid_reg || m_ready;

    assign out_load = (cmd.exec && (in_action_reg == ACT_ADD || in_action_reg == ACT_REMOVE
                                    || (in_action_reg == ACT_TICK && !unit_done)))
                      || (cmd.sweep_step && slot_fires && pend_valid_reg)
                      || cmd.flush;

    always_comb begin
        sts.action     = in_action_reg;
        sts.unit_done  = unit_done;
        sts.slot_fires = slot_fires;
        sts.pend_valid = pend_valid_reg;
        sts.sweep_end  = idx_reg == SLOT_W'(SLOT_COUNT - 1);
        sts.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg        <= TPU_RESET;
            prescale_reg   <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                tpu_reg <= cfg_wdata;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.exec) begin
                case (in_action_reg)
                    ACT_ADD: begin
                        if (free_found) begin
                            active_reg[free_idx] <= 1'b1;
                        end
                    end
                    ACT_REMOVE: begin
                        if (rm_hit) begin
                            active_reg[in_handle_reg[SLOT_W-1:0]] <= 1'b0;
                        end
                    end
                    ACT_TICK: begin
                        if (unit_done) begin
                            prescale_reg   <= '0;
                            idx_reg        <= '0;
                            pend_valid_reg <= 1'b0;
                        end else begin
                            prescale_reg <= presc_inc[UNIT_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.sweep_step) begin
                if (slot_fires) begin
                    // one-shot timer is freed
                    if (cur_reload == '0) begin
                        active_reg[idx_reg] <= 1'b0;
                    end
                    pend_valid_reg <= 1'b1;
                end
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_action_reg <= s_action;
            in_delay_reg  <= s_delay_units;
            in_period_reg <= s_period_units;
            in_handle_reg <= s_handle_in;
        end
        if (cmd.exec) begin
            case (in_action_reg)
                ACT_ADD: begin
                    if (free_found) begin
                        rem_reg[free_idx]    <= (in_delay_reg == '0) ? UNIT_W'(1) : in_delay_reg;
                        reload_reg[free_idx] <= in_period_reg;
                    end
                    out_kind_reg   <= KIND_ADD;
                    out_handle_reg <= free_found ? HANDLE_W'(free_idx) : '0;
                    out_status_reg <= free_found ? ST_OK : ST_FULL;
                    out_last_reg   <= 1'b1;
                end
                ACT_REMOVE: begin
                    out_kind_reg   <= KIND_REMOVE;
                    out_handle_reg <= in_handle_reg;
                    out_status_reg <= rm_hit ? ST_OK : ST_NOT_FOUND;
                    out_last_reg   <= 1'b1;
                end
                ACT_TICK: begin
                    out_kind_reg   <= KIND_EMPTY_TICK;
                    out_handle_reg <= '0;
                    out_status_reg <= ST_OK;
                    out_last_reg   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (cmd.sweep_step && cur_act) begin
            if (cur_rem > UNIT_W'(1)) begin
                rem_reg[idx_reg] <= cur_rem - UNIT_W'(1);
            end else if (cur_reload != '0) begin
                rem_reg[idx_reg] <= cur_reload;
            end
            if (slot_fires) begin
                pend_handle_reg <= idx_reg;
                if (pend_valid_reg) begin
                    out_kind_reg   <= KIND_FIRED;
                    out_handle_reg <= HANDLE_W'(pend_handle_reg);
                    out_status_reg <= ST_OK;
                    out_last_reg   <= 1'b0;
                end
            end
        end
        if (cmd.flush) begin
            out_kind_reg   <= pend_valid_reg ? KIND_FIRED : KIND_EMPTY_TICK;
            out_handle_reg <= pend_valid_reg ? HANDLE_W'(pend_handle_reg) : '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b1;
        end
    end

    assign tpu_value     = tpu_reg;
    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_task_handle = out_handle_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

endmodule

// File: design/periodic_task_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// table of periodic and one-shot timers with prescaled tick input
//
// channel   signals                                            direction
// s_        s_action s_delay_units s_period_units s_handle_in   in
// m_        m_kind m_task_handle m_status m_last                out
// apb       psel penable pwrite paddr pwdata prdata pready     in/out
//
// add, remove and a tick that completes no unit: loaded in S_IDLE, executed in S_EXEC
// a tick that completes a unit also sweeps all SLOT_COUNT slots, one slot per cycle
// unless a firing slot waits for m_ready, and then flushes the final result
// one transfer per fired timer, ascending handle order, last on the final one
// a stalled m_ready holds execution, the final transfer and a second firing
// aresetn is synchronous; all slots free, prescaler zero, ticks_per_unit 10
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_timer_table
    import ptt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [UNIT_W-1:0]     s_delay_units,
    input  logic [UNIT_W-1:0]     s_period_units,
    input  logic [HANDLE_W-1:0]   s_handle_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [HANDLE_W-1:0]   m_task_handle,
    output logic [1:0]            m_status,
    output logic                  m_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    ptt_cmd_t          cmd;
    ptt_sts_t          sts;
    logic              cfg_sel;
    logic              cfg_we;
    logic [UNIT_W-1:0] tpu_value;

    assign cfg_sel = paddr[CFG_ADDR_W-1:2] == REG_TICKS_PER_UNIT;
    assign cfg_we  = psel && penable && pwrite && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? CFG_DATA_W'(tpu_value) : '0;

    ptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_action       (s_action),
        .s_delay_units  (s_delay_units),
        .s_period_units (s_period_units),
        .s_handle_in    (s_handle_in),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[UNIT_W-1:0]),
        .tpu_value      (tpu_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_task_handle  (m_task_handle),
        .m_status       (m_status),
        .m_last         (m_last)
    );

endmodule

// File: design/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks of the periodic task timer table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_task_timer_table_macros.svh"

module ptt_checker
    import ptt_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_kind,
    input logic [HANDLE_W-1:0]   m_task_handle,
    input logic [1:0]            m_status,
    input logic                  m_last
);

    // one item in flight at a time
    `PTT_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "input taken while busy")

    `PTT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_task_handle) && $stable(m_last), "stalled result changed")

    // add and remove replies and empty ticks are single transfers
    `PTT_ASSERT_SAME(a_single_last, m_valid && (m_kind == KIND_ADD || m_kind == KIND_REMOVE || m_kind == KIND_EMPTY_TICK), m_last, "single result not marked last")

    `PTT_ASSERT_SAME(a_fire_ok, m_valid && (m_kind == KIND_FIRED || m_kind == KIND_EMPTY_TICK), m_status == ST_OK, "tick result with bad status")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);
